// ----- hw/rtl/gbd_pkg.sv -----
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared widths, codes, reset tables and types for the banknote dispenser.
// ----------------------------------------------------------------------------
package gbd_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = 3;
   localparam int AMOUNT_W    = 24;
   localparam int VALUE_W     = 12;
   localparam int COUNT_W     = 14;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int DIV_CNT_W   = 5;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IMPOSSIBLE = 2'd2;

   localparam logic [VALUE_W-1:0] VALUE_RESET [SLOTS] = '{
      12'd1, 12'd2, 12'd5, 12'd10, 12'd20, 12'd50, 12'd250, 12'd450
   };

   localparam logic [31:0] STOCK_RESET [SLOTS] = '{
      32'd12800, 32'd6400, 32'd3200, 32'd1600, 32'd800, 32'd400, 32'd200, 32'd100
   };

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/gbd_divider.sv -----
// ----------------------------------------------------------------------------
// gbd_divider
// Restoring divider, amount by note value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbd_divider
   import gbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [AMOUNT_W-1:0] dividend,
   input  logic [VALUE_W-1:0]  divisor,
   output logic [AMOUNT_W-1:0] quotient,
   output div_status_type      sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [AMOUNT_W-1:0]  quo_ff, quo_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0]   div_ff, div_in;
   logic [VALUE_W:0]     shifted;
   logic [VALUE_W:0]     diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[AMOUNT_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(AMOUNT_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[AMOUNT_W-2:0], fits};
         rem_in = fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ----- hw/rtl/greedy_banknote_dispenser_unit.sv -----
// ----------------------------------------------------------------------------
// greedy_banknote_dispenser_unit
// Greedy note breakdown of a requested amount with per-denomination stock.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tdata = amount, tuser = commit. One request item at a time.
//   rsp channel: tuser = status, tdata = eight note counts. One item per
//     request.
//   csr channel: writes note values (index 0..7); always ready, write only
//     while no request is in flight. Other indexes are dropped.
// Sequence: a zero amount goes straight to the result. Otherwise each used
//   denomination runs a divide on the one-bit-per-cycle divider, then a
//   multiply and a subtract; a zero note value is skipped without a divide.
// Flow: req_tready is high only when the sequencer is idle, which it
//   enters as the previous result is loaded. A new request may be taken
//   while the previous result still waits on rsp.
// Reset: note values and stock return to their defaults, no result pending.
// Stall: a finished result holds in the sequencer until the output register
//   is free; a committed OK result deducts stock when it is loaded.
// ----------------------------------------------------------------------------
module greedy_banknote_dispenser_unit
   import gbd_pkg::*;
#(
   parameter int NUM_DENOMS  = 8,
   parameter int STOCK_WIDTH = 14
)
(
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [AMOUNT_W-1:0]      req_tdata,   // [23:0] amount
   input  logic                     req_tuser,   // [0] commit
   // result
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [SLOTS*COUNT_W-1:0] rsp_tdata,   // count_0 [13:0] .. count_7 [111:98]
   output logic [STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [VALUE_W-1:0]       csr_wdata
);

   localparam int CMP_W   = (STOCK_WIDTH > AMOUNT_W) ? STOCK_WIDTH : AMOUNT_W;
   localparam int GIVEN_W = (STOCK_WIDTH > COUNT_W) ? STOCK_WIDTH : COUNT_W;
   localparam logic [SLOT_W-1:0] TOP_IDX = SLOT_W'(NUM_DENOMS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SUB    = 3'd4;
   localparam logic [2:0] ST_EVAL   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [SLOT_W-1:0]          idx_ff, idx_in;
   logic [AMOUNT_W-1:0]        rest_ff, rest_in;
   logic                       commit_ff, commit_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [AMOUNT_W-1:0]        take_ff, take_in;
   logic [AMOUNT_W-1:0]        prod_ff, prod_in;
   logic [GIVEN_W-1:0]         given_ff [SLOTS];
   logic [GIVEN_W-1:0]         given_in [SLOTS];
   logic [STOCK_WIDTH-1:0]     stock_ff [SLOTS];
   logic [STOCK_WIDTH-1:0]     stock_in [SLOTS];
   logic [VALUE_W-1:0]         value_ff [SLOTS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SLOTS*COUNT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]        rsp_user_ff, rsp_user_in;

   logic                       div_start;
   logic [AMOUNT_W-1:0]        div_quo;
   div_status_type             div_sts;
   logic [CMP_W-1:0]           quo_wide;
   logic [CMP_W-1:0]           stock_wide;
   logic [CMP_W-1:0]           take_wide;
   logic [AMOUNT_W+VALUE_W-1:0] prod_full;
   logic                       out_free;

   gbd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rest_ff),
      .divisor  (value_ff[idx_ff]),
      .quotient (div_quo),
      .sts      (div_sts)
   );

   assign quo_wide   = CMP_W'(div_quo);
   assign stock_wide = CMP_W'(stock_ff[idx_ff]);
   assign take_wide  = (quo_wide > stock_wide) ? stock_wide : quo_wide;
   assign prod_full  = take_ff * value_ff[idx_ff];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rest_in      = rest_ff;
      commit_in    = commit_ff;
      status_in    = status_ff;
      take_in      = take_ff;
      prod_in      = prod_ff;
      given_in     = given_ff;
      stock_in     = stock_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rest_in   = req_tdata;
               commit_in = req_tuser;
               idx_in    = TOP_IDX;
               for (int i = 0; i < SLOTS; i++) given_in[i] = '0;
               if (req_tdata == '0) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            // a zero note value gives no notes
            if (value_ff[idx_ff] == '0) begin
               if (idx_ff == '0) begin
                  state_in = ST_EVAL;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               take_in          = AMOUNT_W'(take_wide);
               given_in[idx_ff] = GIVEN_W'(take_wide);
               state_in         = ST_MUL;
            end
         end
         ST_MUL: begin
            // product never exceeds the remaining amount
            prod_in  = prod_full[AMOUNT_W-1:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            rest_in = rest_ff - prod_ff;
            if (idx_ff == '0) begin
               state_in = ST_EVAL;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_EVAL: begin
            status_in = (rest_ff != '0) ? STATUS_IMPOSSIBLE : STATUS_OK;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               for (int i = 0; i < SLOTS; i++) begin
                  rsp_data_in[i*COUNT_W +: COUNT_W] =
                     (status_ff == STATUS_OK) ? given_ff[i][COUNT_W-1:0] : '0;
               end
               if (status_ff == STATUS_OK && commit_ff) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     stock_in[i] = stock_ff[i] - STOCK_WIDTH'(given_ff[i]);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            stock_ff[i] <= STOCK_RESET[i][STOCK_WIDTH-1:0];
            value_ff[i] <= VALUE_RESET[i];
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stock_ff     <= stock_in;
         if (csr_valid && csr_index < CSR_INDEX_W'(SLOTS)) begin
            value_ff[csr_index[SLOT_W-1:0]] <= csr_wdata;
         end
      end
      idx_ff      <= idx_in;
      rest_ff     <= rest_in;
      commit_ff   <= commit_in;
      status_ff   <= status_in;
      take_ff     <= take_in;
      prod_ff     <= prod_in;
      given_ff    <= given_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // divider runs only while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside divide state");

   // failed or invalid requests carry no notes
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff != STATUS_OK) |-> rsp_data_ff == '0)
      else $error("nonzero counts on failed request");

   // stock of the top denomination only ever goes down
   a_stock_down: assert property (@(posedge clock) disable iff (reset)
      !reset |=> stock_ff[TOP_IDX] <= $past(stock_ff[TOP_IDX]))
      else $error("stock increased");

   // a result is loaded only into a free output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_FINISH)
      else $error("result overran pending output");

endmodule
